@@ sv/crp_pkg.sv @@
`timescale 1ns / 1ps
package crp_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int COORD_WIDTH_DEF   = 16;
  localparam int MAX_STAGES        = 24;

  localparam int ANGLE_W     = 16;
  localparam int Z_W         = 32;
  localparam int GUARD_BITS  = 8;
  localparam int HEAD_BITS   = 3;
  localparam int INV_GAIN_W  = 21;
  localparam int GAIN_SHIFT  = 28;

  // 1/K in units of 2^-20
  localparam logic signed [INV_GAIN_W-1:0] INV_GAIN = 21'sd636749;

  localparam logic signed [ANGLE_W-1:0] ANG_QUARTER = 16'sd16384;

  localparam logic KIND_RECT  = 1'b0;
  localparam logic KIND_POLAR = 1'b1;

  // atan(2^-i), 2^31 = pi
  localparam logic [Z_W-1:0] ATAN_TABLE [MAX_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic valid;
    logic polar;
    logic zero;
  } crp_ctrl_t;

endpackage

@@ sv/crp_if.sv @@
`timescale 1ns / 1ps
interface crp_in_if #(parameter int CW = 16);
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic signed [CW-1:0] first_value;
  logic signed [CW-1:0] second_value;

  modport source (output valid, kind, first_value, second_value, input ready);
  modport sink   (input valid, kind, first_value, second_value, output ready);
endinterface

interface crp_out_if #(parameter int CW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] real_out;
  logic signed [CW-1:0] imag_out;
  logic signed [CW:0]   magnitude_out;
  logic signed [15:0]   angle_out;

  modport source (output valid, real_out, imag_out, magnitude_out, angle_out,
                  input ready);
  modport sink   (input valid, real_out, imag_out, magnitude_out, angle_out,
                  output ready);
endinterface

@@ sv/crp_prep.sv @@
`timescale 1ns / 1ps
module crp_prep import crp_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int IW = CW + GUARD_BITS + HEAD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic                 kind,
  input  logic signed [CW-1:0] a,
  input  logic signed [CW-1:0] b,
  output crp_ctrl_t            ctrl_r,
  output logic signed [IW-1:0] x_r,
  output logic signed [IW-1:0] y_r,
  output logic [Z_W-1:0]       z_r,
  output logic [CW-1:0]        pa_r,
  output logic [CW-1:0]        pb_r
);

  logic signed [CW:0]      a_e, b_e, neg_a, neg_b, xm, ym;
  logic [ANGLE_W-1:0]      t, t_f;
  logic                    fold, flip;
  crp_ctrl_t               ctrl_nxt;
  logic signed [IW-1:0]    x_nxt, y_nxt;
  logic [Z_W-1:0]          z_nxt;

  always_comb begin
    a_e   = (CW+1)'(a);
    b_e   = (CW+1)'(b);
    neg_a = -a_e;
    neg_b = -b_e;
    t     = ANGLE_W'($unsigned(b));
    fold  = ($signed(t) > ANG_QUARTER) || ($signed(t) < -ANG_QUARTER);
    // +-pi shift is a flip of the angle MSB
    t_f   = fold ? {~t[ANGLE_W-1], t[ANGLE_W-2:0]} : t;
    flip  = a[CW-1];
    if (kind == KIND_POLAR) begin
      xm    = fold ? neg_a : a_e;
      ym    = '0;
      z_nxt = {t_f, 16'b0};
    end else begin
      xm    = flip ? neg_a : a_e;
      ym    = flip ? neg_b : b_e;
      z_nxt = flip ? {1'b1, {(Z_W-1){1'b0}}} : '0;
    end
    x_nxt = IW'(xm) <<< GUARD_BITS;
    y_nxt = IW'(ym) <<< GUARD_BITS;
    ctrl_nxt.valid = in_valid;
    ctrl_nxt.polar = kind;
    ctrl_nxt.zero  = (kind == KIND_RECT) && (a == '0) && (b == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (en) begin
      ctrl_r <= ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      z_r  <= z_nxt;
      pa_r <= a;
      pb_r <= b;
    end
  end

endmodule

@@ sv/crp_cordic_stage.sv @@
`timescale 1ns / 1ps
module crp_cordic_stage import crp_pkg::*; #(
  parameter int CW    = COORD_WIDTH_DEF,
  parameter int IW    = CW + GUARD_BITS + HEAD_BITS,
  parameter int SHIFT = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  crp_ctrl_t            ctrl_i,
  input  logic signed [IW-1:0] x_i,
  input  logic signed [IW-1:0] y_i,
  input  logic [Z_W-1:0]       z_i,
  input  logic [CW-1:0]        pa_i,
  input  logic [CW-1:0]        pb_i,
  output crp_ctrl_t            ctrl_r,
  output logic signed [IW-1:0] x_r,
  output logic signed [IW-1:0] y_r,
  output logic [Z_W-1:0]       z_r,
  output logic [CW-1:0]        pa_r,
  output logic [CW-1:0]        pb_r
);

  localparam logic [Z_W-1:0] ATAN = ATAN_TABLE[SHIFT];

  logic signed [IW-1:0] dx, dy, x_nxt, y_nxt;
  logic [Z_W-1:0]       z_nxt;
  logic                 pos;

  always_comb begin
    dx  = y_i >>> SHIFT;
    dy  = x_i >>> SHIFT;
    // vectoring drives y to zero, rotation drives z to zero
    pos = ctrl_i.polar ? !z_i[Z_W-1] : y_i[IW-1];
    if (pos) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (en) begin
      ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      z_r  <= z_nxt;
      pa_r <= pa_i;
      pb_r <= pb_i;
    end
  end

endmodule

@@ sv/crp_post.sv @@
`timescale 1ns / 1ps
module crp_post import crp_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int IW = CW + GUARD_BITS + HEAD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  crp_ctrl_t            ctrl_i,
  input  logic signed [IW-1:0] x_i,
  input  logic signed [IW-1:0] y_i,
  input  logic [Z_W-1:0]       z_i,
  input  logic [CW-1:0]        pa_i,
  input  logic [CW-1:0]        pb_i,
  output crp_ctrl_t            ctrl_r,
  output logic signed [CW-1:0] re_r,
  output logic signed [CW-1:0] im_r,
  output logic signed [CW:0]   mag_r,
  output logic [ANGLE_W-1:0]   ang_r
);

  localparam int PW = IW + INV_GAIN_W;
  localparam int RW = PW - GAIN_SHIFT;
  localparam logic signed [RW-1:0] CMAX   = RW'((64'sd1 <<< (CW-1)) - 64'sd1);
  localparam logic signed [RW-1:0] CMIN   = -CMAX - RW'(1);
  localparam logic signed [RW-1:0] MAGMAX = RW'((64'sd1 <<< CW) - 64'sd1);
  localparam logic signed [PW-1:0] HALF   = PW'(64'sd1 <<< (GAIN_SHIFT-1));

  // product stage
  crp_ctrl_t            ctrl_m_r;
  logic signed [PW-1:0] px_r, py_r;
  logic [Z_W-1:0]       zm_r;
  logic [CW-1:0]        pam_r, pbm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_m_r <= '0;
    end else if (en) begin
      ctrl_m_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r  <= PW'(x_i) * PW'(INV_GAIN);
      py_r  <= PW'(y_i) * PW'(INV_GAIN);
      zm_r  <= z_i;
      pam_r <= pa_i;
      pbm_r <= pb_i;
    end
  end

  // round, clip, select
  logic signed [PW-1:0] sx, sy;
  logic signed [RW-1:0] rx, ry;
  logic signed [CW-1:0] re_nxt, im_nxt, cx, cy;
  logic signed [CW:0]   mag_nxt, mclip;
  logic [ANGLE_W-1:0]   ang_nxt;
  logic [Z_W-1:0]       zr;

  always_comb begin
    sx = px_r + HALF;
    sy = py_r + HALF;
    rx = RW'(sx >>> GAIN_SHIFT);
    ry = RW'(sy >>> GAIN_SHIFT);
    cx = (rx > CMAX) ? CW'(CMAX) : ((rx < CMIN) ? CW'(CMIN) : CW'(rx));
    cy = (ry > CMAX) ? CW'(CMAX) : ((ry < CMIN) ? CW'(CMIN) : CW'(ry));
    mclip = (rx < 0) ? '0 : ((rx > MAGMAX) ? (CW+1)'(MAGMAX) : (CW+1)'(rx));
    zr = zm_r + Z_W'(32'h0000_8000);
    if (ctrl_m_r.polar == KIND_POLAR) begin
      re_nxt  = cx;
      im_nxt  = cy;
      mag_nxt = (CW+1)'($signed(pam_r));
      ang_nxt = ANGLE_W'($unsigned(pbm_r));
    end else begin
      re_nxt  = $signed(pam_r);
      im_nxt  = $signed(pbm_r);
      mag_nxt = ctrl_m_r.zero ? '0 : mclip;
      ang_nxt = ctrl_m_r.zero ? '0 : zr[Z_W-1:Z_W-ANGLE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (en) begin
      ctrl_r <= ctrl_m_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      re_r  <= re_nxt;
      im_r  <= im_nxt;
      mag_r <= mag_nxt;
      ang_r <= ang_nxt;
    end
  end

endmodule

@@ sv/complex_rect_polar_converter.sv @@
`timescale 1ns / 1ps
// Rectangular <-> polar converter, pipelined CORDIC.
// in_ch: kind (0 = x/y in Q7.8, 1 = magnitude Q7.8 / binary angle, 0x8000 = pi),
//   first_value, second_value. out_ch: real_out, imag_out, magnitude_out,
//   angle_out, every request giving all four views of the number.
// Path from the accepting edge to out_ch.valid: input prep register, one register
//   per micro-rotation, gain product register, output register. Throughput: one
//   request per cycle while out_ch is not stalled.
// Zero rectangular input gives magnitude 0 and angle 0.
// The whole pipeline advances together; in_ch.ready is high while the
//   output register is empty or being taken. When the receiver stalls, the
//   pipeline freezes and holds every item in flight; nothing is dropped.
// Reset (synchronous, rst_n low) clears all valid bits; payload registers
//   are not reset.
module complex_rect_polar_converter import crp_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  crp_in_if.sink    in_ch,
  crp_out_if.source out_ch
);

  localparam int CW = COORD_WIDTH;
  localparam int IW = CW + GUARD_BITS + HEAD_BITS;
  localparam int NS = CORDIC_STAGES;

  logic      adv;
  crp_ctrl_t out_ctrl;

  crp_ctrl_t            st_ctrl [NS+1];
  logic signed [IW-1:0] st_x    [NS+1];
  logic signed [IW-1:0] st_y    [NS+1];
  logic [Z_W-1:0]       st_z    [NS+1];
  logic [CW-1:0]        st_pa   [NS+1];
  logic [CW-1:0]        st_pb   [NS+1];

  assign adv         = !out_ctrl.valid || out_ch.ready;
  assign in_ch.ready = adv;

  crp_prep #(.CW(CW), .IW(IW)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_ch.valid),
    .kind     (in_ch.kind),
    .a        (in_ch.first_value),
    .b        (in_ch.second_value),
    .ctrl_r   (st_ctrl[0]),
    .x_r      (st_x[0]),
    .y_r      (st_y[0]),
    .z_r      (st_z[0]),
    .pa_r     (st_pa[0]),
    .pb_r     (st_pb[0])
  );

  for (genvar i = 0; i < NS; i++) begin : g_stage
    crp_cordic_stage #(.CW(CW), .IW(IW), .SHIFT(i)) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .ctrl_i (st_ctrl[i]),
      .x_i    (st_x[i]),
      .y_i    (st_y[i]),
      .z_i    (st_z[i]),
      .pa_i   (st_pa[i]),
      .pb_i   (st_pb[i]),
      .ctrl_r (st_ctrl[i+1]),
      .x_r    (st_x[i+1]),
      .y_r    (st_y[i+1]),
      .z_r    (st_z[i+1]),
      .pa_r   (st_pa[i+1]),
      .pb_r   (st_pb[i+1])
    );
  end

  crp_post #(.CW(CW), .IW(IW)) u_post (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .ctrl_i (st_ctrl[NS]),
    .x_i    (st_x[NS]),
    .y_i    (st_y[NS]),
    .z_i    (st_z[NS]),
    .pa_i   (st_pa[NS]),
    .pb_i   (st_pb[NS]),
    .ctrl_r (out_ctrl),
    .re_r   (out_ch.real_out),
    .im_r   (out_ch.imag_out),
    .mag_r  (out_ch.magnitude_out),
    .ang_r  (out_ch.angle_out)
  );

  assign out_ch.valid = out_ctrl.valid;

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled while output register empty");

  a_rect_mag_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ctrl.polar) |-> !out_ch.magnitude_out[CW])
    else $error("negative magnitude from rectangular request");

  a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ctrl.zero) |->
      (out_ch.magnitude_out == '0 && out_ch.angle_out == '0))
    else $error("zero vector gave nonzero magnitude or angle");
`endif

endmodule
